@@ hw/rtl/rau_pkg.sv @@
// rau_pkg: shared types, constants and helpers for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int W = 64;
  localparam int CNT_W = $clog2(W);

  typedef logic signed [W-1:0] word_t;
  typedef logic [W-1:0] uword_t;
  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_REDUCE = 3'd0;
  localparam cmd_t CMD_ADD = 3'd1;
  localparam cmd_t CMD_SUB = 3'd2;
  localparam cmd_t CMD_MUL = 3'd3;
  localparam cmd_t CMD_DIV = 3'd4;

  localparam uword_t TOP_BIT = {1'b1, {(W-1){1'b0}}};
  localparam uword_t UWORD_ONE = {{(W-1){1'b0}}, 1'b1};
  localparam word_t S_MIN = word_t'(TOP_BIT);

  function automatic uword_t mag(input word_t v);
    uword_t r;
    r = v[W-1] ? uword_t'(-v) : uword_t'(v);
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/rau_if.sv @@
// rau_if: valid/ready channel interfaces for operand and result transactions
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
interface rau_in_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  cmd_t cmd;
  word_t a_num;
  word_t a_den;
  word_t b_num;
  word_t b_den;
  modport source(output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  word_t res_num;
  logic [W-2:0] res_den;
  logic invalid;
  modport source(output valid, res_num, res_den, invalid, input ready);
  modport sink(input valid, res_num, res_den, invalid, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rau_gcd.sv @@
// rau_gcd: iterative binary gcd of two magnitudes, one subtract or shift per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire rau_pkg::uword_t a,
  input  wire rau_pkg::uword_t b,
  output logic done,
  output rau_pkg::uword_t res
);
  import rau_pkg::*;
  uword_t x;
  uword_t y;
  logic [CNT_W-1:0] k;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= a;
        y <= b;
        k <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (x == '0) begin
          res <= (y == '0) ? UWORD_ONE : (y << k);
          busy <= 1'b0;
          done <= 1'b1;
        end else if (y == '0) begin
          res <= x;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rau_div.sv @@
// rau_div: restoring unsigned divider, one quotient bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire rau_pkg::uword_t dividend,
  input  wire rau_pkg::uword_t divisor,
  output logic done,
  output rau_pkg::uword_t quot
);
  import rau_pkg::*;
  uword_t rem;
  uword_t dv;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [W:0] trial;
  logic fits;

  assign trial = {rem, quot[W-1]};
  assign fits = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        dv <= divisor;
        rem <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? W'(trial - {1'b0, dv}) : trial[W-1:0];
        quot <= {quot[W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rau_mul.sv @@
// rau_mul: shift-add unsigned multiplier, one multiplier bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
module rau_mul (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire rau_pkg::uword_t a,
  input  wire rau_pkg::uword_t b,
  output logic done,
  output rau_pkg::uword_t hi,
  output rau_pkg::uword_t lo
);
  import rau_pkg::*;
  uword_t ma;
  logic [2*W-1:0] p;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [W:0] sum;

  assign sum = {1'b0, p[2*W-1:W]} + (p[0] ? {1'b0, ma} : {(W+1){1'b0}});
  assign hi = p[2*W-1:W];
  assign lo = p[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma <= a;
        p <= {{W{1'b0}}, b};
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        p <= {sum, p[W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rational_arithmetic_unit.sv @@
// rational_arithmetic_unit: sequencer over gcd, divide and multiply units
// depends on rau_pkg, rau_if, rau_gcd, rau_div, rau_mul
// the bit-serial gcd, divider and multiplier units run one after another, never in
// parallel
// throughput: one transaction at a time, next accepted after the result is taken
// reset: synchronous, returns to idle, any transaction in flight is dropped
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit (
  input wire logic clk,
  input wire logic rst,
  rau_in_if.sink req,
  rau_out_if.source rsp
);
  import rau_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_AS_G = 5'd1;
  localparam logic [4:0] S_AS_X = 5'd2;
  localparam logic [4:0] S_AS_Y = 5'd3;
  localparam logic [4:0] S_AS_L = 5'd4;
  localparam logic [4:0] S_AS_R = 5'd5;
  localparam logic [4:0] S_AS_SUM = 5'd6;
  localparam logic [4:0] S_AS_D = 5'd7;
  localparam logic [4:0] S_ML_G1 = 5'd8;
  localparam logic [4:0] S_ML_G2 = 5'd9;
  localparam logic [4:0] S_ML_X = 5'd10;
  localparam logic [4:0] S_ML_Y = 5'd11;
  localparam logic [4:0] S_ML_N = 5'd12;
  localparam logic [4:0] S_ML_X2 = 5'd13;
  localparam logic [4:0] S_ML_Y2 = 5'd14;
  localparam logic [4:0] S_ML_D = 5'd15;
  localparam logic [4:0] S_MK_CHK = 5'd16;
  localparam logic [4:0] S_MK_G = 5'd17;
  localparam logic [4:0] S_MK_N = 5'd18;
  localparam logic [4:0] S_MK_D = 5'd19;
  localparam logic [4:0] S_MK_FIX = 5'd20;
  localparam logic [4:0] S_OUT = 5'd21;

  logic [4:0] state;
  logic issued;
  logic ret_mul;
  logic sub;
  word_t pn, pd, qn, qd, g1, g2, x, y, n, d;
  word_t res_num;
  logic [W-2:0] res_den;
  logic invalid;

  logic use_gcd, use_div, use_mul;
  word_t opa, opb;
  logic gcd_done, div_done, mul_done;
  uword_t gcd_res, div_q, mul_hi, mul_lo;
  logic unit_done;
  word_t div_val, mul_val;
  logic mul_neg, mul_ok;
  uword_t lim;
  logic [W:0] s;
  logic s_ok;
  word_t nf, df;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.res_num = res_num;
  assign rsp.res_den = res_den;
  assign rsp.invalid = invalid;

  always_comb begin
    use_gcd = 1'b0;
    use_div = 1'b0;
    use_mul = 1'b0;
    opa = '0;
    opb = '0;
    case (state)
      S_AS_G: begin use_gcd = 1'b1; opa = pd; opb = qd; end
      S_AS_X: begin use_div = 1'b1; opa = pd; opb = g1; end
      S_AS_Y: begin use_div = 1'b1; opa = qd; opb = g1; end
      S_AS_L: begin use_mul = 1'b1; opa = pn; opb = y; end
      S_AS_R: begin use_mul = 1'b1; opa = qn; opb = x; end
      S_AS_D: begin use_mul = 1'b1; opa = x; opb = qd; end
      S_ML_G1: begin use_gcd = 1'b1; opa = pn; opb = qd; end
      S_ML_G2: begin use_gcd = 1'b1; opa = qn; opb = pd; end
      S_ML_X: begin use_div = 1'b1; opa = pn; opb = g1; end
      S_ML_Y: begin use_div = 1'b1; opa = qn; opb = g2; end
      S_ML_N: begin use_mul = 1'b1; opa = x; opb = y; end
      S_ML_X2: begin use_div = 1'b1; opa = pd; opb = g2; end
      S_ML_Y2: begin use_div = 1'b1; opa = qd; opb = g1; end
      S_ML_D: begin use_mul = 1'b1; opa = x; opb = y; end
      S_MK_G: begin use_gcd = 1'b1; opa = n; opb = d; end
      S_MK_N: begin use_div = 1'b1; opa = n; opb = g1; end
      S_MK_D: begin use_div = 1'b1; opa = d; opb = g1; end
      default: begin end
    endcase
  end

  rau_gcd u_gcd (
    .clk(clk), .rst(rst), .start(use_gcd && !issued),
    .a(mag(opa)), .b(mag(opb)), .done(gcd_done), .res(gcd_res)
  );

  rau_div u_div (
    .clk(clk), .rst(rst), .start(use_div && !issued),
    .dividend(mag(opa)), .divisor(uword_t'(opb)), .done(div_done), .quot(div_q)
  );

  rau_mul u_mul (
    .clk(clk), .rst(rst), .start(use_mul && !issued),
    .a(mag(opa)), .b(mag(opb)), .done(mul_done), .hi(mul_hi), .lo(mul_lo)
  );

  always_comb begin
    unit_done = (use_gcd && gcd_done) || (use_div && div_done) || (use_mul && mul_done);
    div_val = opa[W-1] ? -word_t'(div_q) : word_t'(div_q);
    mul_neg = opa[W-1] ^ opb[W-1];
    lim = mul_neg ? TOP_BIT : TOP_BIT - UWORD_ONE;
    mul_ok = (mul_hi == '0) && (mul_lo <= lim);
    mul_val = mul_neg ? -word_t'(mul_lo) : word_t'(mul_lo);
    s = sub ? ({n[W-1], n} - {d[W-1], d}) : ({n[W-1], n} + {d[W-1], d});
    s_ok = (s[W] == s[W-1]);
    nf = d[W-1] ? -n : n;
    df = d[W-1] ? -d : d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
      ret_mul <= 1'b0;
    end else begin
      if ((use_gcd || use_div || use_mul) && !issued) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            pn <= req.a_num;
            pd <= req.a_den;
            qn <= req.b_num;
            qd <= req.b_den;
            sub <= (req.cmd == CMD_SUB);
            ret_mul <= 1'b0;
            issued <= 1'b0;
            state <= S_OUT;
            res_num <= '0;
            res_den <= '0;
            invalid <= 1'b1;
            case (req.cmd)
              CMD_REDUCE: begin
                n <= req.a_num;
                d <= req.a_den;
                state <= S_MK_CHK;
              end
              CMD_ADD, CMD_SUB: begin
                if (req.a_den != '0 && req.b_den != '0) state <= S_AS_G;
              end
              CMD_MUL: begin
                if (req.a_den != '0 && req.b_den != '0) state <= S_ML_G1;
              end
              CMD_DIV: begin
                if (req.a_den != '0 && req.b_den != '0 && req.b_num != '0) begin
                  n <= req.b_den;
                  d <= req.b_num;
                  ret_mul <= 1'b1;
                  state <= S_MK_CHK;
                end
              end
              default: begin end
            endcase
          end
        end
        S_AS_SUM: begin
          if (s_ok) begin
            n <= s[W-1:0];
            state <= S_AS_D;
          end else begin
            res_num <= '0;
            res_den <= '0;
            invalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_MK_CHK: begin
          if (d == '0) begin
            res_num <= '0;
            res_den <= '0;
            invalid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_MK_G;
          end
        end
        S_MK_FIX: begin
          if (d[W-1] && (n == S_MIN || d == S_MIN)) begin
            res_num <= '0;
            res_den <= '0;
            invalid <= 1'b1;
            state <= S_OUT;
          end else if (ret_mul) begin
            qn <= nf;
            qd <= df;
            ret_mul <= 1'b0;
            state <= S_ML_G1;
          end else begin
            res_num <= nf;
            res_den <= df[W-2:0];
            invalid <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: begin
          if (unit_done) begin
            issued <= 1'b0;
            if (use_mul && !mul_ok) begin
              res_num <= '0;
              res_den <= '0;
              invalid <= 1'b1;
              state <= S_OUT;
            end else begin
              case (state)
                S_AS_G: begin g1 <= word_t'(gcd_res); state <= S_AS_X; end
                S_AS_X: begin x <= div_val; state <= S_AS_Y; end
                S_AS_Y: begin y <= div_val; state <= S_AS_L; end
                S_AS_L: begin n <= mul_val; state <= S_AS_R; end
                S_AS_R: begin d <= mul_val; state <= S_AS_SUM; end
                S_AS_D: begin d <= mul_val; state <= S_MK_CHK; end
                S_ML_G1: begin g1 <= word_t'(gcd_res); state <= S_ML_G2; end
                S_ML_G2: begin g2 <= word_t'(gcd_res); state <= S_ML_X; end
                S_ML_X: begin x <= div_val; state <= S_ML_Y; end
                S_ML_Y: begin y <= div_val; state <= S_ML_N; end
                S_ML_N: begin n <= mul_val; state <= S_ML_X2; end
                S_ML_X2: begin x <= div_val; state <= S_ML_Y2; end
                S_ML_Y2: begin y <= div_val; state <= S_ML_D; end
                S_ML_D: begin d <= mul_val; state <= S_MK_CHK; end
                S_MK_G: begin g1 <= word_t'(gcd_res); state <= S_MK_N; end
                S_MK_N: begin n <= div_val; state <= S_MK_D; end
                S_MK_D: begin d <= div_val; state <= S_MK_FIX; end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for rational_arithmetic_unit, exact gcd-reduced fraction math
// depends on rau_pkg, rau_if and the rtl of rational_arithmetic_unit
// scoreboard class predicts each result and checks it in order on the result channel
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rau_pkg::*;

  localparam int N_RANDOM = 1500;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam longint S_LO = S_MIN;
  localparam longint S_HI = ~S_MIN;

  typedef struct {
    longint n;
    longint d;
  } frac_t;

  typedef struct {
    longint num;
    logic [62:0] den;
    logic inv;
  } rau_result_t;

  class rational_scoreboard;
    rau_result_t expected_results[$];
    int errors = 0;
    int checked = 0;
    int invalid_seen = 0;

    function longint unsigned abs_u(longint x);
      longint unsigned u;
      u = x;
      return x < 0 ? -u : u;
    endfunction

    function longint unsigned gcd_u(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = y;
        y = x % y;
        x = t;
      end
      return x != 0 ? x : 1;
    endfunction

    function longint div_exact(longint v, longint unsigned f);
      longint unsigned q;
      q = abs_u(v) / f;
      return v < 0 ? longint'(-q) : longint'(q);
    endfunction

    function bit mul_chk(longint x, longint y, output longint r);
      longint unsigned mx, my, lim, p;
      bit neg;
      mx = abs_u(x);
      my = abs_u(y);
      neg = (x < 0) != (y < 0);
      r = 0;
      if (mx == 0 || my == 0) return 1;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (my > lim / mx) return 0;
      p = mx * my;
      r = neg ? longint'(-p) : longint'(p);
      return 1;
    endfunction

    function bit addsub_chk(longint x, longint y, bit sub, output longint r);
      if (sub) begin
        r = x - y;
        return !((x < 0) != (y < 0) && (r < 0) != (x < 0));
      end
      r = x + y;
      return !((x < 0) == (y < 0) && (r < 0) != (x < 0));
    endfunction

    function frac_t reduce_frac(longint n, longint d);
      frac_t r;
      longint unsigned g;
      r = '{0, 0};
      if (d == 0) return r;
      g = gcd_u(abs_u(n), abs_u(d));
      r.n = div_exact(n, g);
      r.d = div_exact(d, g);
      if (r.d < 0) begin
        if (r.n == S_LO || r.d == S_LO) return '{0, 0};
        r.n = -r.n;
        r.d = -r.d;
      end
      return r;
    endfunction

    function frac_t add_frac(frac_t p, frac_t q, bit sub);
      longint unsigned g;
      longint pg, qg, l, rr, n, d;
      bit ok;
      if (p.d == 0 || q.d == 0) return '{0, 0};
      g = gcd_u(abs_u(p.d), abs_u(q.d));
      pg = div_exact(p.d, g);
      qg = div_exact(q.d, g);
      ok = mul_chk(p.n, qg, l);
      if (ok) ok = mul_chk(q.n, pg, rr);
      if (ok) ok = addsub_chk(l, rr, sub, n);
      if (ok) ok = mul_chk(pg, q.d, d);
      if (!ok) return '{0, 0};
      return reduce_frac(n, d);
    endfunction

    function frac_t mul_frac(frac_t p, frac_t q);
      longint unsigned g1, g2;
      longint n, d;
      if (p.d == 0 || q.d == 0) return '{0, 0};
      g1 = gcd_u(abs_u(p.n), abs_u(q.d));
      g2 = gcd_u(abs_u(q.n), abs_u(p.d));
      if (!mul_chk(div_exact(p.n, g1), div_exact(q.n, g2), n)) return '{0, 0};
      if (!mul_chk(div_exact(p.d, g2), div_exact(q.d, g1), d)) return '{0, 0};
      return reduce_frac(n, d);
    endfunction

    function frac_t div_frac(frac_t p, frac_t q);
      frac_t rc;
      if (p.d == 0 || q.d == 0 || q.n == 0) return '{0, 0};
      rc = reduce_frac(q.d, q.n);
      if (rc.d == 0) return '{0, 0};
      return mul_frac(p, rc);
    endfunction

    function void note_input(cmd_t op, longint an, longint ad, longint bn, longint bd);
      frac_t a, b, r;
      rau_result_t e;
      a = '{an, ad};
      b = '{bn, bd};
      case (op)
        CMD_REDUCE: r = reduce_frac(an, ad);
        CMD_ADD: r = add_frac(a, b, 0);
        CMD_SUB: r = add_frac(a, b, 1);
        CMD_MUL: r = mul_frac(a, b);
        CMD_DIV: r = div_frac(a, b);
        default: r = '{0, 0};
      endcase
      e.num = r.n;
      e.den = r.d[62:0];
      e.inv = (r.d == 0);
      expected_results.push_back(e);
    endfunction

    function void check_result(longint num, logic [62:0] den, logic inv);
      rau_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d inv=%0b", $time, num, den, inv);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (inv) invalid_seen++;
      if (num !== e.num) begin
        $display("%0t: res_num expected %0d actual %0d", $time, e.num, num);
        errors++;
      end
      if (den !== e.den) begin
        $display("%0t: res_den expected %0d actual %0d", $time, e.den, den);
        errors++;
      end
      if (inv !== e.inv) begin
        $display("%0t: invalid expected %0b actual %0b", $time, e.inv, inv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  rau_in_if req();
  rau_out_if rsp();
  rational_scoreboard sb = new();
  longint cycles = 0;
  int n_sent = 0;
  int op_count[8];
  bit holdoff_req = 0;
  int holdoff_cnt = 0;
  int stall_mode = 0;
  int mode_left = 0;

  rational_arithmetic_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: checks transactions, stalls on its own pattern
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.res_num, rsp.res_den, rsp.invalid);
    if (holdoff_req && holdoff_cnt == 0) holdoff_cnt = 3000;
    if (holdoff_cnt > 0) begin
      holdoff_cnt--;
      if (holdoff_cnt == 0) holdoff_req = 0;
      rsp.ready <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (stall_mode)
        0: rsp.ready <= 1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic longint rand_word();
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = longint'($urandom_range(0, 40)) - 20;
      3, 4: v = longint'($signed($urandom_range(0, 65535) - 32768));
      5: v = longint'($signed($urandom()));
      6, 7: v = {$urandom(), $urandom()};
      default: begin
        case ($urandom_range(0, 5))
          0: v = S_LO;
          1: v = S_HI;
          2: v = S_LO + 1;
          3: v = 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_item(cmd_t op, longint an, longint ad, longint bn, longint bd,
                           int gap);
    req.valid <= 1;
    req.cmd <= op;
    req.a_num <= an;
    req.a_den <= ad;
    req.b_num <= bn;
    req.b_den <= bd;
    do @(posedge clk); while (!req.ready);
    sb.note_input(op, an, ad, bn, bd);
    n_sent++;
    op_count[op]++;
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  int burst_left = 0;

  task automatic send_random();
    cmd_t op;
    int gap;
    op = ($urandom_range(0, 19) == 0) ? cmd_t'($urandom_range(5, 7))
                                       : cmd_t'($urandom_range(0, 4));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 20);
    end else gap = 0;
    burst_left--;
    send_item(op, rand_word(), rand_word(), rand_word(), rand_word(),
              burst_left == 0 ? gap : 0);
  endtask

  initial begin
    longint wait_cnt;
    req.valid = 0;
    req.cmd = CMD_REDUCE;
    req.a_num = 0;
    req.a_den = 0;
    req.b_num = 0;
    req.b_den = 0;
    rsp.ready = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners
    send_item(CMD_REDUCE, 6, -4, 0, 0, 0);
    send_item(CMD_REDUCE, 5, 0, 0, 0, 0);
    send_item(CMD_REDUCE, 0, 7, 0, 0, 2);
    send_item(CMD_REDUCE, S_LO, -1, 0, 0, 0);
    send_item(CMD_REDUCE, S_LO, S_LO, 0, 0, 0);
    send_item(CMD_REDUCE, S_HI, S_LO, 0, 0, 1);
    send_item(CMD_ADD, 1, S_LO, 1, S_LO, 0);
    send_item(CMD_ADD, S_HI, 1, 1, 1, 0);
    send_item(CMD_ADD, 1, 6, 1, 0, 0);
    send_item(CMD_SUB, S_LO, 1, 1, 1, 3);
    send_item(CMD_SUB, 3, 4, -5, 6, 0);
    send_item(CMD_SUB, S_LO, S_HI, S_HI, S_LO, 0);
    send_item(CMD_MUL, S_HI, 1, 2, 1, 0);
    send_item(CMD_MUL, S_LO, 3, 3, -1, 0);
    send_item(CMD_MUL, -4, 9, 3, 8, 0);
    send_item(CMD_MUL, 0, 0, 1, 1, 0);
    send_item(CMD_DIV, 1, 2, 0, 5, 0);
    send_item(CMD_DIV, 3, 7, S_LO, -1, 0);
    send_item(CMD_DIV, -2, 3, -4, 9, 0);
    send_item(CMD_DIV, S_HI, S_LO, S_LO, S_HI, 0);
    send_item(cmd_t'(5), 1, 1, 1, 1, 0);
    send_item(cmd_t'(6), 2, 3, 4, 5, 0);
    send_item(cmd_t'(7), -1, -1, -1, -1, 4);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) holdoff_req = 1;
      send_random();
    end
    req.valid <= 0;

    wait_cnt = 0;
    while (sb.expected_results.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    $display("sent %0d transactions: reduce %0d add %0d sub %0d mul %0d div %0d unused %0d",
             n_sent, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5] + op_count[6] + op_count[7]);
    $display("checked %0d results, %0d invalid, %0d left over, %0d mismatches",
             sb.checked, sb.invalid_seen, sb.expected_results.size(), sb.errors);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
